FILE: src/ffba_pkg.sv
`default_nettype none
package ffba_pkg;

	localparam int DEF_HEADER_BYTES = 24;
	localparam int DEF_HEAP_BYTES   = 65536;
	localparam int DEF_MAX_BLOCKS   = 64;

	localparam logic MODE_ALLOC   = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_SPACE  = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic        mode;
		logic [15:0] request_bytes;
		logic [15:0] release_offset;
	} in_item_t;

	typedef struct packed {
		logic [15:0] payload_offset;
		logic [1:0]  status;
		logic [15:0] released_bytes;
	} out_item_t;

	typedef struct packed {
		logic load_item;
		logic scan;
		logic append;
		logic out_load;
	} ffba_cmd_t;

	typedef struct packed {
		logic hit;
		logic scan_done;
		logic is_alloc;
	} ffba_sts_t;

endpackage
`default_nettype wire

FILE: src/ffba_datapath.sv
`default_nettype none
module ffba_datapath
	import ffba_pkg::*;
#(
	parameter int HEADER_BYTES = DEF_HEADER_BYTES,
	parameter int HEAP_BYTES   = DEF_HEAP_BYTES,
	parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire ffba_cmd_t cmd,
	output      ffba_sts_t sts,
	input  wire in_item_t  req,
	output      out_item_t rsp
);

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int HW = $clog2(HEAP_BYTES + 1);
	localparam int NW = ((HW > 16) ? HW : 16) + 2;

	typedef struct packed {
		logic [15:0] offset;
		logic [15:0] bytes;
		logic        in_use;
	} entry_t;

	entry_t    mem [MAX_BLOCKS];
	entry_t    rd_data_q;
	in_item_t  item_q;
	out_item_t res_q;
	out_item_t rsp_q;
	logic [CW-1:0] addr_q;
	logic [CW-1:0] count_q;
	logic [HW-1:0] heap_top_q;
	logic [IW-1:0] data_idx_q;
	logic          chk_valid_q;

	logic          rd_en;
	logic          alloc;
	logic          hit;
	logic          scan_done;
	logic          room;
	logic          append_ok;
	logic          mem_we;
	logic [IW-1:0] wr_idx;
	entry_t        wr_entry;
	logic [NW-1:0] pay;
	logic [NW-1:0] need;
	logic          res_load;
	out_item_t     res_d;

	assign alloc = (item_q.mode == MODE_ALLOC);
	assign rd_en = cmd.scan && (addr_q < count_q);
	assign hit = cmd.scan && chk_valid_q && (alloc
		? (!rd_data_q.in_use && (rd_data_q.bytes >= item_q.request_bytes))
		: (rd_data_q.offset == item_q.release_offset));
	assign scan_done = cmd.scan && !chk_valid_q && !(addr_q < count_q);

	assign pay  = NW'(heap_top_q) + NW'(HEADER_BYTES);
	assign need = pay + NW'(item_q.request_bytes);
	assign room = (count_q < CW'(MAX_BLOCKS)) && (need <= NW'(HEAP_BYTES))
		&& (pay[NW-1:16] == '0);
	assign append_ok = cmd.append && room;

	assign mem_we = hit || append_ok;
	assign wr_idx = hit ? data_idx_q : count_q[IW-1:0];

	always_comb begin
		wr_entry = '0;
		res_d    = '0;
		res_load = 1'b0;
		if (hit) begin
			res_load        = 1'b1;
			wr_entry.offset = rd_data_q.offset;
			res_d.status    = ST_OK;
			if (alloc) begin
				wr_entry.bytes       = item_q.request_bytes;
				wr_entry.in_use      = 1'b1;
				res_d.payload_offset = rd_data_q.offset;
			end else begin
				wr_entry.bytes       = rd_data_q.bytes;
				wr_entry.in_use      = 1'b0;
				res_d.released_bytes = rd_data_q.bytes;
			end
		end else if (scan_done && !alloc) begin
			res_load     = 1'b1;
			res_d.status = ST_NOT_FOUND;
		end else if (cmd.append) begin
			res_load        = 1'b1;
			wr_entry.offset = pay[15:0];
			wr_entry.bytes  = item_q.request_bytes;
			wr_entry.in_use = 1'b1;
			if (room) begin
				res_d.payload_offset = pay[15:0];
				res_d.status         = ST_OK;
			end else begin
				res_d.status = ST_NO_SPACE;
			end
		end
	end

	// block table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_idx] <= wr_entry;
		end
		if (rd_en) begin
			rd_data_q <= mem[addr_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= req;
		end
		if (rd_en) begin
			data_idx_q <= addr_q[IW-1:0];
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if (cmd.out_load) begin
			rsp_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			chk_valid_q <= 1'b0;
			count_q     <= '0;
			heap_top_q  <= '0;
		end else begin
			if (cmd.load_item) begin
				addr_q      <= '0;
				chk_valid_q <= 1'b0;
			end else if (cmd.scan) begin
				chk_valid_q <= rd_en;
				if (rd_en) begin
					addr_q <= addr_q + CW'(1);
				end
			end
			if (append_ok) begin
				count_q    <= count_q + CW'(1);
				heap_top_q <= need[HW-1:0];
			end
		end
	end

	assign sts.hit       = hit;
	assign sts.scan_done = scan_done;
	assign sts.is_alloc  = alloc;
	assign rsp           = rsp_q;

endmodule
`default_nettype wire

FILE: src/ffba_ctrl.sv
`default_nettype none
module ffba_ctrl
	import ffba_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output      logic      req_ready,
	output      logic      rsp_valid,
	input  wire logic      rsp_ready,
	output      ffba_cmd_t cmd,
	input  wire ffba_sts_t sts
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_APPEND = 2'd2;
	localparam logic [1:0] S_OUT    = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					state_d = S_OUT;
				end else if (sts.scan_done) begin
					state_d = sts.is_alloc ? S_APPEND : S_OUT;
				end
			end
			S_APPEND: begin
				cmd.append = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_hit_excl_done: assert property (@(posedge clk) disable iff (!arst_n)
		sts.hit |-> !sts.scan_done)
		else $error("hit and end of scan in the same cycle");

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == S_SCAN))
		else $error("accepted transfer did not start a scan");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || rsp_ready))
		else $error("output register overwritten while held");

	a_release_no_append: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && sts.scan_done && !sts.is_alloc) |=> (state_q == S_OUT))
		else $error("release miss went to append");

endmodule
`default_nettype wire

FILE: src/first_fit_block_allocator.sv
`default_nettype none
// First-fit heap block allocator.
// Request channel (req_valid/req_ready/req): mode 0 allocates request_bytes,
// mode 1 releases the block whose payload offset equals release_offset.
// Response channel (rsp_valid/rsp_ready/rsp): exactly one transfer per
// request carrying payload_offset, status and released_bytes.
// One request is worked at a time. The block table lives in a single-port-
// read memory that is scanned one entry per cycle in creation order, with
// the compare in the cycle after the read. The scan stops early on a hit;
// an allocation that finds no fitting free block appends a new one. The
// next request is taken once the response moves to the output register.
// A finished response sits in an output register, so the next request is
// taken while the receiver stalls; only a second finished response waits
// for rsp_ready. Reset clears the block count and heap top (empty heap);
// table entries need no clearing since only entries below the count are read.
module first_fit_block_allocator
	import ffba_pkg::*;
#(
	parameter int HEADER_BYTES = DEF_HEADER_BYTES,
	parameter int HEAP_BYTES   = DEF_HEAP_BYTES,
	parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output      logic      req_ready,
	input  wire in_item_t  req,
	output      logic      rsp_valid,
	input  wire logic      rsp_ready,
	output      out_item_t rsp
);

	// command and status between sequencer and datapath
	ffba_cmd_t cmd;
	ffba_sts_t sts;

	// sequencer: accept, scan, append, hand off to the output register
	ffba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// table memory, scan pointer, heap top and response registers
	ffba_datapath #(
		.HEADER_BYTES (HEADER_BYTES),
		.HEAP_BYTES   (HEAP_BYTES),
		.MAX_BLOCKS   (MAX_BLOCKS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire
